// ===== src/xmr_pkg.sv =====
// Package for the XMODEM-1K CRC receiver: codes, phases, config indexes,
// command/status structs shared by the controller and the datapath.
// No dependencies.
package xmr_pkg;

   localparam int MAX_BLOCK_BYTES = 1024;
   localparam int SHORT_LEN       = 128;
   localparam int ADDR_W          = $clog2(MAX_BLOCK_BYTES);
   localparam int CNT_W           = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int CHUNK_W         = $clog2((MAX_BLOCK_BYTES + 15) / 16 + 1);
   localparam int LONG_CHUNKS     = (MAX_BLOCK_BYTES + 15) / 16;
   localparam int SHORT_CHUNKS    = SHORT_LEN / 16;

   localparam logic [7:0] C_SOH  = 8'h01;
   localparam logic [7:0] C_STX  = 8'h02;
   localparam logic [7:0] C_EOT  = 8'h04;
   localparam logic [7:0] C_ACK  = 8'h06;
   localparam logic [7:0] C_NAK  = 8'h15;
   localparam logic [7:0] C_CAN  = 8'h18;
   localparam logic [7:0] C_POLL = 8'h43;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [2:0] REG_DEST_BASE  = 3'd0;
   localparam logic [2:0] REG_POLL_TICKS = 3'd1;
   localparam logic [2:0] REG_START_TRY  = 3'd2;
   localparam logic [2:0] REG_CAN_WAIT   = 3'd3;
   localparam logic [2:0] REG_STALL      = 3'd4;

   localparam logic [2:0] ST_RUN    = 3'd0;
   localparam logic [2:0] ST_DONE   = 3'd1;
   localparam logic [2:0] ST_CANCEL = 3'd2;
   localparam logic [2:0] ST_OOS    = 3'd3;
   localparam logic [2:0] ST_STALL  = 3'd4;
   localparam logic [2:0] ST_NOSEND = 3'd5;

   typedef enum logic [3:0] {
      PH_IDLE, PH_POLL, PH_HEADER, PH_CANWAIT, PH_NUM, PH_INV, PH_DATA,
      PH_CRCH, PH_CRCL, PH_DONE, PH_CANCEL, PH_OOS, PH_STALL, PH_NOSENDER
   } phase_type;

   // sequencer states
   typedef enum logic [2:0] {
      SQ_IDLE, SQ_EMIT1, SQ_EMIT2, SQ_READ, SQ_WAIT, SQ_CHUNK
   } seq_type;

   // commands from the controller into the datapath
   typedef struct packed {
      logic       start;      // clear transfer counters
      logic       store;      // write data byte, advance crc and count
      logic       rd_start;   // begin reading a chunk
      logic       commit;     // bump offset and block number
      logic       tally;      // add block length to byte total
      logic       latch_num;
      logic       latch_inv;
      logic       latch_crch;
      logic       latch_crcl;
      logic       chunk_next; // move to next chunk
      logic       set_long;
      logic       long_val;
   } cmd_type;

   // status from the datapath
   typedef struct packed {
      logic       block_full;
      logic       check_ok;    // complement and crc good (uses final low byte)
      logic       num_expected;
      logic       num_previous;
      logic       rd_done;     // chunk bytes assembled
      logic       last_chunk;
   } stat_type;

   function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

endpackage

// ===== src/xmodem_1k_crc_receiver.sv =====
// Top level of the XMODEM-1K CRC-16 receiver: config registers and the
// controller/datapath pair. Uses xmr_pkg, xmr_controller, xmr_datapath.
//
//  channel | direction | payload
//  req_    | in        | tdata: kind[1:0], rx_byte[9:2]
//  rsp_    | out       | tdata: tx_valid, tx_byte, write_valid, address, data, status,
//          |           |        total_bytes ; tlast: last
//  csr_    | in        | index[2:0], data[63:0]
//
// A committed block drains in 16-byte chunks, each read one byte at a time,
// bound by the single read port of the block store.
// Reset is synchronous and restores register defaults. Output stalls hold the
// result register and stop intake.
module xmodem_1k_crc_receiver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // kind[1:0], rx_byte[9:2], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [247:0] rsp_tdata,   // tx_valid[0], tx_byte[8:1], write_valid[9],
                                     // write_address[73:10], write_data_low[137:74],
                                     // write_data_high[201:138], status[204:202],
                                     // total_bytes[236:205], zero pad
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   import xmr_pkg::*;

   logic [63:0] base_ff;
   logic [31:0] poll_ff, canw_ff, stall_ff;
   logic [7:0]  tries_ff;
   cmd_type     cmd;
   stat_type    stat;
   logic [63:0] caddr;
   logic [127:0] cdata;
   logic [31:0] total;
   logic        txv, wv, lst;
   logic [7:0]  txb;
   logic [2:0]  st;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0; poll_ff <= 32'd66666666; tries_ff <= 8'd30;
         canw_ff <= 32'd33333333; stall_ff <= 32'd3333333330;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DEST_BASE:  base_ff  <= csr_data;
            REG_POLL_TICKS: poll_ff  <= csr_data[31:0];
            REG_START_TRY:  tries_ff <= csr_data[7:0];
            REG_CAN_WAIT:   canw_ff  <= csr_data[31:0];
            REG_STALL:      stall_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   xmr_controller u_ctl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .kind(req_tdata[1:0]), .rx_byte(req_tdata[9:2]),
      .poll_ticks(poll_ff), .start_tries(tries_ff),
      .can_wait_ticks(canw_ff), .stall_ticks(stall_ff),
      .cmd(cmd), .stat(stat),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .o_txv(txv), .o_txb(txb), .o_wv(wv), .o_last(lst), .o_status(st)
   );

   xmr_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .rx_byte(req_tdata[9:2]),
      .dest_base(base_ff), .stat(stat),
      .chunk_addr(caddr), .chunk_data(cdata), .total(total)
   );

   // address and data registers for the result beat
   logic [63:0] waddr_ff;
   logic [127:0] wdata_ff;
   always_ff @(posedge clock) begin
      if (!rsp_tvalid || rsp_tready) begin
         waddr_ff <= caddr; wdata_ff <= cdata;
      end
   end

   assign rsp_tdata = {11'd0, total, st,
                       wv ? wdata_ff : 128'd0, wv ? waddr_ff : 64'd0,
                       wv, txb, txv};
   assign rsp_tlast = lst;

endmodule

// ===== src/xmr_datapath.sv =====
// Datapath of the XMODEM-1K receiver: block store, crc, header fields,
// chunk assembly, write offset and byte total. Uses xmr_pkg.
module xmr_datapath (
   input  logic              clock,
   input  logic              reset,
   input  xmr_pkg::cmd_type  cmd,
   input  logic [7:0]        rx_byte,
   input  logic [63:0]       dest_base,
   output xmr_pkg::stat_type stat,
   output logic [63:0]       chunk_addr,
   output logic [127:0]      chunk_data,
   output logic [31:0]       total
);
   import xmr_pkg::*;

   logic [7:0]   mem [MAX_BLOCK_BYTES];
   logic [7:0]   rd_q;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [15:0]  crc_ff, crc_in;
   logic [7:0]   num_ff, inv_ff, exp_ff, crch_ff;
   logic         long_ff;
   logic [63:0]  off_ff;
   logic [31:0]  tot_ff;
   logic [CHUNK_W-1:0] chunk_ff;
   logic [4:0]   ri_ff;          // byte index within the chunk being read
   logic         rvalid_ff;      // rd_q holds byte ri_ff-1
   logic         busy_ff;
   logic [127:0] data_ff;
   logic [CNT_W-1:0] len;
   logic [CHUNK_W-1:0] nchunks;
   logic [ADDR_W+4:0] bidx;
   logic [ADDR_W+4:0] ridx;
   logic [3:0]   slot;           // chunk byte that rd_q lands in
   logic [32:0]  tsum;
   logic [15:0]  rcrc;

   assign len     = long_ff ? CNT_W'(MAX_BLOCK_BYTES) : CNT_W'(SHORT_LEN);
   assign nchunks = long_ff ? CHUNK_W'(LONG_CHUNKS) : CHUNK_W'(SHORT_CHUNKS);
   assign cnt_in  = cnt_ff + 1'b1;
   assign crc_in  = crc_byte(crc_ff, rx_byte);
   // first read cycle fetches byte 0, then one byte ahead of the slot
   assign bidx    = (ADDR_W+5)'(chunk_ff) * 16 + (ADDR_W+5)'(rvalid_ff ? ri_ff : 5'd0);
   assign ridx    = (ADDR_W+5)'(chunk_ff) * 16 + (ADDR_W+5)'(ri_ff - 5'd1);
   assign slot    = ri_ff[3:0] - 4'd1;
   assign tsum    = {1'b0, tot_ff} + 33'(len);
   assign rcrc    = {crch_ff, rx_byte};

   // block store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store && cnt_ff < CNT_W'(MAX_BLOCK_BYTES))
         mem[cnt_ff[ADDR_W-1:0]] <= rx_byte;
      rd_q <= mem[bidx[ADDR_W-1:0]];
   end

   // header fields, crc, byte count, write offset and byte total
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; crc_ff <= '0; long_ff <= 1'b0; exp_ff <= 8'd1;
         num_ff <= '0; inv_ff <= '0; crch_ff <= '0;
         off_ff <= '0; tot_ff <= '0;
      end else begin
         if (cmd.start) begin
            exp_ff <= 8'd1; off_ff <= '0; tot_ff <= '0; long_ff <= 1'b0;
         end
         if (cmd.set_long) begin
            long_ff <= cmd.long_val; cnt_ff <= '0; crc_ff <= '0;
         end
         if (cmd.store) begin
            cnt_ff <= cnt_in; crc_ff <= crc_in;
         end
         if (cmd.latch_num)  num_ff  <= rx_byte;
         if (cmd.latch_inv)  inv_ff  <= rx_byte;
         if (cmd.latch_crch) crch_ff <= rx_byte;
         // total moves before the drain so every chunk beat shows it
         if (cmd.tally)
            tot_ff <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
         if (cmd.commit) begin
            off_ff <= off_ff + 64'(len);
            exp_ff <= exp_ff + 8'd1;
         end
      end
   end

   // chunk reader: 16 bytes, one per cycle, out of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rvalid_ff <= 1'b0; ri_ff <= '0; chunk_ff <= '0;
      end else begin
         if (cmd.commit) chunk_ff <= '0;
         if (cmd.chunk_next) chunk_ff <= chunk_ff + 1'b1;
         if (cmd.rd_start) begin
            busy_ff <= 1'b1; ri_ff <= 5'd1; rvalid_ff <= 1'b0;
         end else if (busy_ff) begin
            rvalid_ff <= 1'b1;
            if (rvalid_ff) begin
               if (ri_ff == 5'd16) busy_ff <= 1'b0;
               else ri_ff <= ri_ff + 5'd1;
            end
         end
      end
   end

   // rd_q arrives in the cycle after its address; write each byte into its slot
   always_ff @(posedge clock) begin
      if (busy_ff && rvalid_ff)
         data_ff[slot*8 +: 8] <= (ridx < (ADDR_W+5)'(len)) ? rd_q : 8'h00;
   end

   // the read address is presented in the cycle before rd_q lands
   always_comb begin
      stat.block_full   = cnt_in >= len;
      stat.check_ok     = ((num_ff ^ inv_ff) == 8'hFF) && (crc_ff == rcrc);
      stat.num_expected = num_ff == exp_ff;
      stat.num_previous = num_ff == exp_ff - 8'd1;
      stat.rd_done      = !busy_ff;
      stat.last_chunk   = chunk_ff + 1'b1 == nchunks;
   end

   assign chunk_addr = dest_base + off_ff + 64'({chunk_ff, 4'd0});
   assign chunk_data = data_ff;
   assign total      = tot_ff;

endmodule

// ===== src/xmr_controller.sv =====
// Controller of the XMODEM-1K receiver: protocol phase, timers, poll count
// and the result sequencer. Uses xmr_pkg and drives xmr_datapath.
module xmr_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        kind,
   input  logic [7:0]        rx_byte,
   input  logic [31:0]       poll_ticks,
   input  logic [7:0]        start_tries,
   input  logic [31:0]       can_wait_ticks,
   input  logic [31:0]       stall_ticks,
   output xmr_pkg::cmd_type  cmd,
   input  xmr_pkg::stat_type stat,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              o_txv,
   output logic [7:0]        o_txb,
   output logic              o_wv,
   output logic              o_last,
   output logic [2:0]        o_status
);
   import xmr_pkg::*;

   phase_type   ph_ff, ph_in;
   seq_type     sq_ff, sq_in;
   logic [7:0]  polls_ff, polls_in;
   logic [31:0] tmr_ff, tmr_in;
   logic [7:0]  b1_ff, b1_in, b2_ff, b2_in;   // queued tx bytes
   logic        v1_ff, v1_in, v2_ff, v2_in;
   logic        ov_ff, ov_in, otxv_ff, otxv_in, owv_ff, owv_in, olast_ff, olast_in;
   logic [7:0]  otxb_ff, otxb_in;
   logic        acc, expired;

   assign acc     = in_valid && in_ready;
   assign in_ready = sq_ff == SQ_IDLE && !ov_ff;
   assign expired = tmr_ff <= 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE; sq_ff <= SQ_IDLE; polls_ff <= '0; tmr_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; ov_ff <= 1'b0;
         otxv_ff <= 1'b0; owv_ff <= 1'b0; olast_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; sq_ff <= sq_in; polls_ff <= polls_in; tmr_ff <= tmr_in;
         v1_ff <= v1_in; v2_ff <= v2_in; ov_ff <= ov_in;
         otxv_ff <= otxv_in; owv_ff <= owv_in; olast_ff <= olast_in;
      end
      b1_ff <= b1_in; b2_ff <= b2_in; otxb_ff <= otxb_in;
   end

   always_comb begin
      ph_in = ph_ff; sq_in = sq_ff; polls_in = polls_ff; tmr_in = tmr_ff;
      b1_in = b1_ff; b2_in = b2_ff; v1_in = v1_ff; v2_in = v2_ff;
      ov_in = ov_ff; otxv_in = otxv_ff; otxb_in = otxb_ff;
      owv_in = owv_ff; olast_in = olast_ff;
      cmd = '0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (sq_ff)
         SQ_IDLE: begin
            if (acc) begin
               v1_in = 1'b0; v2_in = 1'b0; b1_in = 8'h00; b2_in = 8'h00;
               sq_in = SQ_EMIT1;
               priority case (kind)
                  KIND_START: begin
                     cmd.start = 1'b1;
                     polls_in = (start_tries == 8'd0) ? 8'd0 : start_tries - 8'd1;
                     tmr_in = poll_ticks; ph_in = PH_POLL;
                     v1_in = 1'b1; b1_in = C_POLL;
                  end
                  KIND_BYTE: begin
                     unique case (ph_ff)
                        PH_POLL, PH_HEADER: begin
                           if (rx_byte == C_EOT) begin
                              v1_in = 1'b1; b1_in = C_ACK; ph_in = PH_DONE;
                           end else if (rx_byte == C_CAN) begin
                              ph_in = PH_CANWAIT; tmr_in = can_wait_ticks;
                           end else if (rx_byte == C_SOH || rx_byte == C_STX) begin
                              cmd.set_long = 1'b1; cmd.long_val = rx_byte == C_STX;
                              ph_in = PH_NUM;
                           end else begin
                              ph_in = PH_HEADER; tmr_in = stall_ticks;
                           end
                        end
                        PH_CANWAIT: begin
                           if (rx_byte == C_CAN) begin
                              v1_in = 1'b1; b1_in = C_ACK; ph_in = PH_CANCEL;
                           end else begin
                              ph_in = PH_HEADER; tmr_in = stall_ticks;
                           end
                        end
                        PH_NUM: begin cmd.latch_num = 1'b1; ph_in = PH_INV; end
                        PH_INV: begin cmd.latch_inv = 1'b1; ph_in = PH_DATA; end
                        PH_DATA: begin
                           cmd.store = 1'b1;
                           if (stat.block_full) ph_in = PH_CRCH;
                        end
                        PH_CRCH: begin cmd.latch_crch = 1'b1; ph_in = PH_CRCL; end
                        PH_CRCL: begin
                           ph_in = PH_HEADER; tmr_in = stall_ticks;
                           if (!stat.check_ok) begin
                              v1_in = 1'b1; b1_in = C_NAK;
                           end else if (stat.num_expected) begin
                              cmd.tally = 1'b1;
                              cmd.rd_start = 1'b1; sq_in = SQ_READ;
                           end else if (stat.num_previous) begin
                              v1_in = 1'b1; b1_in = C_ACK;
                           end else begin
                              v1_in = 1'b1; b1_in = C_CAN; v2_in = 1'b1; b2_in = C_CAN;
                              ph_in = PH_OOS;
                           end
                        end
                        default: ;
                     endcase
                  end
                  KIND_TICK: begin
                     if (ph_ff == PH_POLL) begin
                        if (expired) begin
                           tmr_in = 32'd0;
                           if (polls_ff == 8'd0) ph_in = PH_NOSENDER;
                           else begin
                              polls_in = polls_ff - 8'd1; v1_in = 1'b1; b1_in = C_POLL;
                              tmr_in = poll_ticks;
                           end
                        end else tmr_in = tmr_ff - 32'd1;
                     end else if (ph_ff == PH_HEADER) begin
                        if (expired) begin
                           tmr_in = 32'd0; ph_in = PH_STALL;
                           v1_in = 1'b1; b1_in = C_CAN; v2_in = 1'b1; b2_in = C_CAN;
                        end else tmr_in = tmr_ff - 32'd1;
                     end else if (ph_ff == PH_CANWAIT) begin
                        if (expired) begin
                           ph_in = PH_HEADER; tmr_in = stall_ticks;
                        end else tmr_in = tmr_ff - 32'd1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SQ_EMIT1: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1; otxv_in = v1_ff; otxb_in = v1_ff ? b1_ff : 8'h00;
               owv_in = 1'b0; olast_in = !v2_ff;
               sq_in = v2_ff ? SQ_EMIT2 : SQ_IDLE;
            end
         end
         SQ_EMIT2: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1; otxv_in = 1'b1; otxb_in = b2_ff;
               owv_in = 1'b0; olast_in = 1'b1; sq_in = SQ_IDLE;
            end
         end
         SQ_READ: sq_in = SQ_WAIT;
         SQ_WAIT: if (stat.rd_done) sq_in = SQ_CHUNK;
         SQ_CHUNK: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1; owv_in = 1'b1; otxv_in = stat.last_chunk;
               otxb_in = stat.last_chunk ? C_ACK : 8'h00;
               olast_in = stat.last_chunk;
               if (stat.last_chunk) begin
                  cmd.commit = 1'b1; sq_in = SQ_IDLE;
               end else begin
                  cmd.chunk_next = 1'b1; sq_in = SQ_READ;
               end
            end
         end
         default: sq_in = SQ_IDLE;
      endcase
      if (sq_ff == SQ_READ) cmd.rd_start = 1'b1;
      if (sq_ff == SQ_IDLE && acc && kind == KIND_BYTE && ph_ff == PH_CRCL)
         cmd.rd_start = 1'b0;
   end

   always_comb begin
      unique case (ph_ff)
         PH_DONE:     o_status = ST_DONE;
         PH_CANCEL:   o_status = ST_CANCEL;
         PH_OOS:      o_status = ST_OOS;
         PH_STALL:    o_status = ST_STALL;
         PH_NOSENDER: o_status = ST_NOSEND;
         default:     o_status = ST_RUN;
      endcase
   end

   assign out_valid = ov_ff;
   assign o_txv = otxv_ff;
   assign o_txb = otxb_ff;
   assign o_wv = owv_ff;
   assign o_last = olast_ff;

   // no new item while the sequencer is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      sq_ff != SQ_IDLE |-> !in_ready) else $error("accepted while busy");
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(olast_ff)) else $error("result dropped");
   // commit only from the chunk state
   a_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sq_ff == SQ_CHUNK) else $error("stray commit");

endmodule
